### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### hdl/lfdc_pkg.sv
// ----------------------------------------------------------------------------
// lfdc_pkg
// Types, constants and pattern decode for the line follower drive controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfdc_pkg;

  localparam int unsigned SENSOR_W = 5;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned PULSE_W  = 15;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DUTY_W-1:0]   FULL_DUTY      = 8'd255;
  localparam logic [PULSE_W-1:0]  SLAP_PULSE_0   = 15'd550;
  localparam logic [PULSE_W-1:0]  SLAP_PULSE_180 = 15'd2300;
  localparam logic [SENSOR_W-1:0] PAT_ALL_BLACK  = 5'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_GENTLE_GOAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MED_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAP_TICKS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_PULSE     = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_APPROACH = 2'd1,
    PH_SLAP     = 2'd2,
    PH_RESUME   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SIDE_FWD   = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2,
    SIDE_STOP  = 2'd3
  } side_e;

  typedef enum logic [1:0] {
    KIND_SLOW = 2'd0,
    KIND_MED  = 2'd1,
    KIND_FAST = 2'd2
  } kind_e;

  typedef struct packed {
    side_e side;
    kind_e kind;
  } class_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  gentle_goal;
    logic [DUTY_W-1:0]  slow_step;
    logic [DUTY_W-1:0]  med_step;
    logic [DUTY_W-1:0]  fast_step;
    logic [DUTY_W-1:0]  approach_ticks;
    logic [DUTY_W-1:0]  stop_ticks;
    logic [DUTY_W-1:0]  slap_ticks;
    logic [PULSE_W-1:0] rest_pulse;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_rate;
    logic [DUTY_W-1:0] right_rate;
    phase_e            seq_phase;
    logic [DUTY_W-1:0] ticks_left;
    logic              slap_side;
  } state_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  left_drive;
    logic [DUTY_W-1:0]  right_drive;
    logic [PULSE_W-1:0] servo_pulse;
  } result_t;

  function automatic class_t lfdc_classify(input logic [SENSOR_W-1:0] pat);
    class_t c;
    c.side = SIDE_FWD;
    c.kind = KIND_SLOW;
    case (pat) inside
      5'd19, 5'd23:        begin c.side = SIDE_LEFT;  c.kind = KIND_SLOW; end
      5'd25, 5'd29:        begin c.side = SIDE_RIGHT; c.kind = KIND_SLOW; end
      5'd3, 5'd11:         begin c.side = SIDE_LEFT;  c.kind = KIND_MED;  end
      5'd24, 5'd26:        begin c.side = SIDE_RIGHT; c.kind = KIND_MED;  end
      5'd1, 5'd7, 5'd15:   begin c.side = SIDE_LEFT;  c.kind = KIND_FAST; end
      5'd16, 5'd28, 5'd30: begin c.side = SIDE_RIGHT; c.kind = KIND_FAST; end
      default:             begin c.side = SIDE_FWD;   c.kind = KIND_SLOW; end
    endcase
    return c;
  endfunction

endpackage

### hdl/lfdc_in_if.sv
// ----------------------------------------------------------------------------
// lfdc_in_if
// Sensor word channel: valid/ready handshake with the sensor pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfdc_in_if import lfdc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensors;

  modport source (output valid, output sensors, input ready);
  modport sink   (input valid, input sensors, output ready);
endinterface

### hdl/lfdc_out_if.sv
// ----------------------------------------------------------------------------
// lfdc_out_if
// Drive word channel: valid/ready handshake with motor duties and servo pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfdc_out_if import lfdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  left_drive;
  logic [DUTY_W-1:0]  right_drive;
  logic [PULSE_W-1:0] servo_pulse;

  modport source (output valid, output left_drive, output right_drive,
                  output servo_pulse, input ready);
  modport sink   (input valid, input left_drive, input right_drive,
                  input servo_pulse, output ready);
endinterface

### hdl/lfdc_step.sv
// ----------------------------------------------------------------------------
// lfdc_step
// Per-tick combinational update: turn rate ramp, stop sequence, drive outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfdc_step import lfdc_pkg::*; (
  input  logic [SENSOR_W-1:0] sensors_i,
  input  cfg_t                cfg_i,
  input  state_t              state_i,
  output state_t              state_o,
  output result_t             res_o
);

  class_t            cls;
  side_e             side;
  logic [DUTY_W-1:0] ticks_dec;
  logic [DUTY_W-1:0] goal;
  logic [DUTY_W-1:0] up;
  logic [DUTY_W-1:0] cap;
  logic [DUTY_W-1:0] cur;
  logic [DUTY_W:0]   sum;
  logic [DUTY_W:0]   dif;
  logic [DUTY_W-1:0] ramped;
  logic [DUTY_W-1:0] limited;
  logic [DUTY_W-1:0] turn_duty;

  always_comb begin
    cls       = lfdc_classify(sensors_i);
    ticks_dec = (state_i.ticks_left != '0) ? state_i.ticks_left - 8'd1 : '0;

    state_o            = state_i;
    state_o.ticks_left = ticks_dec;
    side               = cls.side;

    if (sensors_i == PAT_ALL_BLACK) begin
      case (state_i.seq_phase)
        PH_IDLE: begin
          side               = SIDE_FWD;
          state_o.seq_phase  = PH_APPROACH;
          state_o.ticks_left = cfg_i.approach_ticks;
        end
        PH_APPROACH: begin
          side = SIDE_STOP;
          if (ticks_dec == '0) begin
            state_o.seq_phase  = PH_SLAP;
            state_o.ticks_left = cfg_i.stop_ticks;
          end
        end
        PH_SLAP: begin
          side = SIDE_STOP;
          if (ticks_dec == '0) begin
            state_o.seq_phase  = PH_RESUME;
            state_o.ticks_left = cfg_i.slap_ticks;
          end
        end
        PH_RESUME: begin
          side = SIDE_FWD;
          if (ticks_dec == '0) begin
            state_o.seq_phase = PH_IDLE;
            state_o.slap_side = ~state_i.slap_side;
          end
        end
        default: begin
          side = SIDE_FWD;
        end
      endcase
    end

    case (cls.kind)
      KIND_SLOW: begin
        goal = cfg_i.gentle_goal; up = cfg_i.slow_step; cap = cfg_i.gentle_goal;
      end
      KIND_MED: begin
        goal = FULL_DUTY; up = cfg_i.med_step; cap = cfg_i.gentle_goal;
      end
      KIND_FAST: begin goal = FULL_DUTY; up = cfg_i.fast_step; cap = FULL_DUTY; end
      default:   begin goal = FULL_DUTY; up = cfg_i.fast_step; cap = FULL_DUTY; end
    endcase

    cur = (side == SIDE_LEFT) ? state_i.left_rate : state_i.right_rate;
    sum = {1'b0, cur} + {1'b0, up};
    dif = {1'b0, cur} - {1'b0, cfg_i.fast_step};

    if (cur < goal) begin
      ramped = (sum < {1'b0, goal}) ? sum[DUTY_W-1:0] : goal;
    end else if (cur > goal) begin
      ramped = (!dif[DUTY_W] && (dif[DUTY_W-1:0] > goal)) ? dif[DUTY_W-1:0] : goal;
    end else begin
      ramped = cur;
    end

    limited   = (ramped < cap) ? ramped : cap;
    turn_duty = FULL_DUTY - limited;

    res_o.servo_pulse = (state_i.seq_phase == PH_SLAP)
                      ? (state_i.slap_side ? SLAP_PULSE_180 : SLAP_PULSE_0)
                      : cfg_i.rest_pulse;
    res_o.left_drive  = FULL_DUTY;
    res_o.right_drive = FULL_DUTY;
    state_o.left_rate  = '0;
    state_o.right_rate = '0;

    case (side)
      SIDE_LEFT: begin
        state_o.left_rate = ramped;
        res_o.right_drive = turn_duty;
      end
      SIDE_RIGHT: begin
        state_o.right_rate = ramped;
        res_o.left_drive   = turn_duty;
      end
      SIDE_STOP: begin
        res_o.left_drive  = '0;
        res_o.right_drive = '0;
      end
      default: begin
        res_o.left_drive  = FULL_DUTY;
        res_o.right_drive = FULL_DUTY;
      end
    endcase
  end

endmodule

### hdl/line_follower_drive_controller.sv
// ----------------------------------------------------------------------------
// line_follower_drive_controller
// Turns one line-sensor word per tick into motor duties and a servo pulse.
// ----------------------------------------------------------------------------
// One sensor word in gives one drive word out, in order. The block takes a
// word every clock cycle unless the output stalls; each word passes an
// input register and a result register, and its drive word is offered on
// the output once the result register holds it. The combinational state
// update in lfdc_step (turn-rate ramp and stop sequence) is what allows one
// word per cycle without a stall. The input register keeps taking one more
// word while a result waits on the output. Configuration writes are applied
// on the next edge and should be done while no word is in flight.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module line_follower_drive_controller import lfdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PULSE_W-1:0]   cfg_data_i,
  lfdc_in_if.sink              in_i,
  lfdc_out_if.source           out_o
);

  cfg_t                cfg_q;
  state_t              state_q;
  state_t              state_d;
  result_t             res_d;
  result_t             res_q;
  logic                s1_valid_q;
  logic [SENSOR_W-1:0] s1_sensors_q;
  logic                out_valid_q;
  logic                advance;
  logic                in_take;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.left_drive  = res_q.left_drive;
  assign out_o.right_drive = res_q.right_drive;
  assign out_o.servo_pulse = res_q.servo_pulse;

  lfdc_step u_step (
    .sensors_i (s1_sensors_q),
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gentle_goal    <= 8'd200;
      cfg_q.slow_step      <= 8'd30;
      cfg_q.med_step       <= 8'd50;
      cfg_q.fast_step      <= 8'd100;
      cfg_q.approach_ticks <= 8'd15;
      cfg_q.stop_ticks     <= 8'd30;
      cfg_q.slap_ticks     <= 8'd60;
      cfg_q.rest_pulse     <= 15'd1400;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GENTLE_GOAL:    cfg_q.gentle_goal    <= cfg_data_i[DUTY_W-1:0];
        CFG_SLOW_STEP:      cfg_q.slow_step      <= cfg_data_i[DUTY_W-1:0];
        CFG_MED_STEP:       cfg_q.med_step       <= cfg_data_i[DUTY_W-1:0];
        CFG_FAST_STEP:      cfg_q.fast_step      <= cfg_data_i[DUTY_W-1:0];
        CFG_APPROACH_TICKS: cfg_q.approach_ticks <= cfg_data_i[DUTY_W-1:0];
        CFG_STOP_TICKS:     cfg_q.stop_ticks     <= cfg_data_i[DUTY_W-1:0];
        CFG_SLAP_TICKS:     cfg_q.slap_ticks     <= cfg_data_i[DUTY_W-1:0];
        CFG_REST_PULSE:     cfg_q.rest_pulse     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.left_rate  <= '0;
      state_q.right_rate <= '0;
      state_q.seq_phase  <= PH_IDLE;
      state_q.ticks_left <= '0;
      state_q.slap_side  <= 1'b1;
      s1_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sensors_q <= in_i.sensors;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  `ASSERT_NEXT(a_state_holds, clk_i, rst_ni, !advance, $stable(state_q))
  `ASSERT_IMPL(a_stall_blocks_in, clk_i, rst_ni,
    s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready)
  `ASSERT_NEXT(a_slap_pulse, clk_i, rst_ni, advance && (state_q.seq_phase == PH_SLAP),
    (res_q.servo_pulse == SLAP_PULSE_0) || (res_q.servo_pulse == SLAP_PULSE_180))
  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, advance, out_valid_q)

endmodule
